// ===== rtl/spf_pkg.sv =====
// Package for the sensor packet framer.
// Holds the item and beat structs, register indexes and reset constants.
// No dependencies.
package spf_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 2'd1;

  localparam logic [15:0] HEADER_RESET  = 16'hEF01;
  localparam logic [31:0] ADDRESS_RESET = 32'hFFFF_FFFF;

  // one accepted input transaction
  typedef struct packed {
    logic [7:0]  packet_id;
    logic [15:0] payload_count;
    logic [7:0]  payload_byte;
    logic        first_byte;
    logic        final_byte;
  } item_t;

  // one framed output byte
  typedef struct packed {
    logic [7:0] wire_byte;
    logic       run_end;
    logic       packet_end;
  } beat_t;

endpackage

// ===== rtl/spf_seq.sv =====
// Byte sequencer of the sensor packet framer: walks one item through the
// header, payload and checksum steps and keeps the running checksum.
// Depends on spf_pkg.
module spf_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  spf_pkg::item_t     item,
  input  logic [15:0]        header_word,
  input  logic [31:0]        device_address,
  input  logic               beat_ready,
  output logic               item_take,
  output logic               beat_valid,
  output spf_pkg::beat_t     beat
);

  localparam logic [3:0] STEP_HDR_HI  = 4'd0;
  localparam logic [3:0] STEP_HDR_LO  = 4'd1;
  localparam logic [3:0] STEP_ADDR_3  = 4'd2;
  localparam logic [3:0] STEP_ADDR_2  = 4'd3;
  localparam logic [3:0] STEP_ADDR_1  = 4'd4;
  localparam logic [3:0] STEP_ADDR_0  = 4'd5;
  localparam logic [3:0] STEP_ID      = 4'd6;
  localparam logic [3:0] STEP_LEN_HI  = 4'd7;
  localparam logic [3:0] STEP_LEN_LO  = 4'd8;
  localparam logic [3:0] STEP_PAYLOAD = 4'd9;
  localparam logic [3:0] STEP_SUM_HI  = 4'd10;
  localparam logic [3:0] STEP_SUM_LO  = 4'd11;

  logic [3:0]  step_r, step_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        open_r, open_nxt;
  logic [3:0]  step_cur;
  logic [3:0]  step_end;
  logic [15:0] len;
  logic [15:0] sum_base;
  logic        drop;
  logic        advance;

  // pick the step for this cycle; a fresh item starts at the header or payload
  always_comb begin
    step_cur = step_r;
    if (step_r == STEP_HDR_HI) begin
      step_cur = item.first_byte ? STEP_HDR_HI : STEP_PAYLOAD;
    end
    step_end = item.final_byte ? STEP_SUM_LO : STEP_PAYLOAD;
    len      = item.payload_count + 16'd2;
    sum_base = item.first_byte
             ? ({8'd0, item.packet_id} + {8'd0, len[15:8]} + {8'd0, len[7:0]})
             : sum_r;
  end

  // drop a continuation byte that arrives while no packet is open
  assign drop       = item_valid && !item.first_byte && !open_r && (step_r == STEP_HDR_HI);
  assign advance    = item_valid && !drop && beat_ready;
  assign beat_valid = item_valid && !drop;
  assign item_take  = drop || (advance && (step_cur == step_end));

  // select the byte for the current step
  always_comb begin
    beat.run_end    = (step_cur == step_end);
    beat.packet_end = (step_cur == STEP_SUM_LO);
    case (step_cur)
      STEP_HDR_HI:  beat.wire_byte = header_word[15:8];
      STEP_HDR_LO:  beat.wire_byte = header_word[7:0];
      STEP_ADDR_3:  beat.wire_byte = device_address[31:24];
      STEP_ADDR_2:  beat.wire_byte = device_address[23:16];
      STEP_ADDR_1:  beat.wire_byte = device_address[15:8];
      STEP_ADDR_0:  beat.wire_byte = device_address[7:0];
      STEP_ID:      beat.wire_byte = item.packet_id;
      STEP_LEN_HI:  beat.wire_byte = len[15:8];
      STEP_LEN_LO:  beat.wire_byte = len[7:0];
      STEP_PAYLOAD: beat.wire_byte = item.payload_byte;
      STEP_SUM_HI:  beat.wire_byte = sum_r[15:8];
      STEP_SUM_LO:  beat.wire_byte = sum_r[7:0];
      default:      beat.wire_byte = 8'd0;
    endcase
  end

  // advance the step counter, fold the payload byte into the checksum, clear it after the low checksum byte
  always_comb begin
    step_nxt = step_r;
    sum_nxt  = sum_r;
    open_nxt = open_r;
    if (advance) begin
      step_nxt = (step_cur == step_end) ? STEP_HDR_HI : step_cur + 4'd1;
      if (step_cur == STEP_PAYLOAD) begin
        sum_nxt  = sum_base + {8'd0, item.payload_byte};
        open_nxt = 1'b1;
      end
      if (step_cur == STEP_SUM_LO) begin
        sum_nxt  = 16'd0;
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_HDR_HI;
      sum_r  <= 16'd0;
      open_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      sum_r  <= sum_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ===== rtl/spf_obuf.sv =====
// Output register of the sensor packet framer: holds one beat until the
// downstream side takes it. Depends on spf_pkg.
module spf_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           beat_valid,
  input  spf_pkg::beat_t beat,
  output logic           beat_ready,
  output logic           out_valid,
  output spf_pkg::beat_t out_beat,
  input  logic           out_ready
);

  logic           valid_r, valid_nxt;
  spf_pkg::beat_t beat_r;

  assign beat_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_beat   = beat_r;

  // hold the beat while stalled, refill when it leaves or the register is empty
  always_comb begin
    valid_nxt = valid_r;
    if (beat_ready) begin
      valid_nxt = beat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_ready && beat_valid) begin
      beat_r <= beat;
    end
  end

endmodule

// ===== rtl/sensor_packet_framer.sv =====
// Top level of the sensor packet framer: input register, configuration
// registers, byte sequencer and output register. Depends on spf_pkg,
// spf_seq and spf_obuf.
//
//  channel  | direction | tdata / data                       | side bits
//  ---------+-----------+------------------------------------+----------------------------
//  in_      | slave     | packet_id, payload_count, byte     | tuser first, tlast final
//  out_     | master    | wire_byte                          | tuser packet end, tlast run end
//  cfg_     | slave     | cfg_index, cfg_data                | -
//
// One output byte per cycle unless the output stalls, paced by the output register. A first byte of a
// packet gives 10 bytes (12 if it also ends the packet), a later byte gives 1
// (3 on the last byte); a byte outside any open packet is dropped without output.
// Reset is synchronous: it clears the valid flags, step counter and checksum and
// loads the configuration defaults; the block is ready right after. An output
// stall holds the output register and backs up into the input register; cfg_ready stays high.
module sensor_packet_framer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] packet_id, [23:8] payload_count, [31:24] payload_byte
  input  logic [31:0]                    in_tdata,
  // [0] first_byte
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [7:0] wire_byte
  output logic [7:0]                     out_tdata,
  // [0] packet_end
  output logic                           out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spf_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           buf_valid_r, buf_valid_nxt;
  spf_pkg::item_t buf_r;
  logic [15:0]    header_r;
  logic [31:0]    address_r;
  logic           item_take;
  logic           seq_valid;
  spf_pkg::beat_t seq_beat;
  logic           seq_ready;
  spf_pkg::beat_t out_beat;
  logic           in_accept;

  assign cfg_ready = 1'b1;

  // write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= spf_pkg::HEADER_RESET;
      address_r <= spf_pkg::ADDRESS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        spf_pkg::REG_HEADER:  header_r  <= cfg_data[15:0];
        spf_pkg::REG_ADDRESS: address_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // input register: refill in the same cycle the sequencer retires an item
  assign in_tready = !buf_valid_r || item_take;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    buf_valid_nxt = buf_valid_r;
    if (item_take) begin
      buf_valid_nxt = 1'b0;
    end
    if (in_accept) begin
      buf_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      buf_r.packet_id     <= in_tdata[7:0];
      buf_r.payload_count <= in_tdata[23:8];
      buf_r.payload_byte  <= in_tdata[31:24];
      buf_r.first_byte    <= in_tuser;
      buf_r.final_byte    <= in_tlast;
    end
  end

  spf_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (buf_valid_r),
    .item           (buf_r),
    .header_word    (header_r),
    .device_address (address_r),
    .beat_ready     (seq_ready),
    .item_take      (item_take),
    .beat_valid     (seq_valid),
    .beat           (seq_beat)
  );

  spf_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (seq_valid),
    .beat       (seq_beat),
    .beat_ready (seq_ready),
    .out_valid  (out_tvalid),
    .out_beat   (out_beat),
    .out_ready  (out_tready)
  );

  assign out_tdata = out_beat.wire_byte;
  assign out_tlast = out_beat.run_end;
  assign out_tuser = out_beat.packet_end;

endmodule

// ===== rtl/spf_check.sv =====
// Port checker for the sensor packet framer, bound to the top level.
// Depends on the output and configuration ports of sensor_packet_framer.
module spf_check (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // the low checksum byte always closes the run of its input transaction
  a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("packet end without run end");

  // nothing leaves in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write not taken");

endmodule

bind sensor_packet_framer spf_check u_check (.*);
